>>> hdl/modbus_rtu_slave_frame_handler_macros.svh
// Assertion macros for the frame handler checker.
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_MACROS_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_MACROS_SVH

// Checked outside reset only.
`define MRTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MRTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mrtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int FRAME_AW      = $clog2(FRAME_BYTES);
  localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
  localparam int HOLDING_COUNT = 10;
  localparam int HOLD_AW       = $clog2(HOLDING_COUNT);
  localparam int MIN_FRAME     = 8;
  localparam int MAX_OUT       = 32;
  localparam int WR_LIMIT      = 4;
  localparam int COIL_COUNT    = 8;
  localparam int COIL_W        = $clog2(COIL_COUNT);

  // byte positions in a request
  localparam int IDX_STATION = 0;
  localparam int IDX_FUNC    = 1;
  localparam int IDX_ADDR_HI = 2;
  localparam int IDX_ADDR_LO = 3;
  localparam int IDX_COUNT   = 5;
  localparam int IDX_BCOUNT  = 6;
  localparam int IDX_WR_DATA = 7;

  // response layout
  localparam int RESP_CNT_POS = 2;
  localparam int RESP_HDR     = 3;
  localparam int RESP_OVH     = 5;
  localparam int RESP_WR_LEN  = 8;
  localparam int RD_MAX_COUNT = (MAX_OUT - RESP_OVH) / 2;

  localparam logic [7:0]  BROADCAST     = 8'hFA;
  localparam logic [7:0]  FN_READ_REGS  = 8'h03;
  localparam logic [7:0]  FN_WRITE_REGS = 8'h10;
  localparam logic [7:0]  FN_READ_COILS = 8'h01;
  localparam logic [7:0]  FN_WRITE_COIL = 8'h05;
  localparam logic [7:0]  COIL_ON       = 8'hAA;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_beat_t;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_CHECK,
    ST_COIL,
    ST_WR_HI,
    ST_WR_MID,
    ST_WR_LO,
    ST_PREP,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    RD_RESP,
    RD_WR_HI,
    RD_WR_LO
  } rd_sel_t;

  typedef struct packed {
    logic    rx_en;
    logic    resp_start;
    logic    coil_wr;
    rd_sel_t rd_sel;
    logic    hi_latch;
    logic    reg_wr;
    logic    k_clr;
    logic    tx_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic ok_rd_regs;
    logic ok_wr_regs;
    logic ok_rd_coils;
    logic ok_wr_coil;
    logic count_zero;
    logic wr_last;
    logic tx_free;
    logic resp_last;
  } dp_status_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mrtu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mrtu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  mrtu_pkg::dp_status_t    st,
  output mrtu_pkg::ctl_cmd_t      cmd
);

  mrtu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrtu_pkg::ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mrtu_pkg::ST_RECV: begin
        if (st.frame_done) state_next = mrtu_pkg::ST_CHECK;
      end
      mrtu_pkg::ST_CHECK: begin
        if (st.ok_rd_regs || st.ok_rd_coils) begin
          state_next = mrtu_pkg::ST_PREP;
        end else if (st.ok_wr_regs) begin
          state_next = st.count_zero ? mrtu_pkg::ST_PREP : mrtu_pkg::ST_WR_HI;
        end else if (st.ok_wr_coil) begin
          state_next = mrtu_pkg::ST_COIL;
        end else begin
          state_next = mrtu_pkg::ST_RECV;
        end
      end
      mrtu_pkg::ST_COIL:   state_next = mrtu_pkg::ST_PREP;
      mrtu_pkg::ST_WR_HI:  state_next = mrtu_pkg::ST_WR_MID;
      mrtu_pkg::ST_WR_MID: state_next = mrtu_pkg::ST_WR_LO;
      mrtu_pkg::ST_WR_LO: begin
        state_next = st.wr_last ? mrtu_pkg::ST_PREP : mrtu_pkg::ST_WR_HI;
      end
      mrtu_pkg::ST_PREP:   state_next = mrtu_pkg::ST_SEND;
      mrtu_pkg::ST_SEND: begin
        if (st.tx_free) state_next = st.resp_last ? mrtu_pkg::ST_RECV : mrtu_pkg::ST_PREP;
      end
      default: state_next = mrtu_pkg::ST_RECV;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = mrtu_pkg::RD_RESP;
    case (state)
      mrtu_pkg::ST_RECV:  cmd.rx_en = 1'b1;
      mrtu_pkg::ST_CHECK: cmd.resp_start = 1'b1;
      mrtu_pkg::ST_COIL:  cmd.coil_wr = 1'b1;
      mrtu_pkg::ST_WR_HI: cmd.rd_sel = mrtu_pkg::RD_WR_HI;
      mrtu_pkg::ST_WR_MID: begin
        cmd.hi_latch = 1'b1;
        cmd.rd_sel   = mrtu_pkg::RD_WR_LO;
      end
      mrtu_pkg::ST_WR_LO: begin
        cmd.reg_wr = 1'b1;
        cmd.k_clr  = st.wr_last;
      end
      mrtu_pkg::ST_PREP:  cmd.rd_sel = mrtu_pkg::RD_RESP;
      mrtu_pkg::ST_SEND:  cmd.tx_load = st.tx_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/mrtu_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mrtu_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  mrtu_pkg::ctl_cmd_t       cmd,
  output mrtu_pkg::dp_status_t     st,
  input  wire logic                rx_valid,
  output logic                     rx_stall,
  input  mrtu_pkg::rx_beat_t       rx_data,
  output logic                     tx_valid,
  input  wire logic                tx_stall,
  output mrtu_pkg::tx_beat_t       tx_data
);

  localparam int CW = mrtu_pkg::CNT_W;
  localparam int AW = mrtu_pkg::FRAME_AW;
  localparam int HW = mrtu_pkg::HOLD_AW;
  localparam int PW = mrtu_pkg::COIL_W;

  logic [7:0]  frame_mem [mrtu_pkg::FRAME_BYTES];
  logic [15:0] holding_regs [mrtu_pkg::HOLDING_COUNT];

  logic [CW-1:0] byte_count;
  logic          overflow_seen;
  logic [CW-1:0] len;
  logic          len_ov;
  logic [15:0]   rx_crc;
  logic [7:0]    station, func, addr_hi, addr_lo, count, bcount;
  logic [7:0]    rd_data;
  logic [7:0]    hi_byte;
  logic [CW-1:0] k;
  logic [CW-1:0] resp_len;
  logic [15:0]   tx_crc;

  logic          accept, store;
  logic [15:0]   crc_base;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] wr_off;
  logic [15:0]   addr;
  logic [16:0]   addr_sum;
  logic          base_ok;
  logic [CW-1:0] resp_len_calc;
  logic [CW-1:0] j;
  logic [CW-1:0] rd_idx;
  logic [15:0]   rd_word;
  logic [HW-1:0] wr_idx;
  logic [7:0]    coils, coils_next;
  logic [PW-1:0] coil_rd_idx, coil_wr_idx;
  logic          crc_lo, crc_hi;
  logic [7:0]    resp_byte;

  assign accept   = cmd.rx_en && rx_valid;
  assign store    = accept && (byte_count < CW'(mrtu_pkg::FRAME_BYTES));
  assign rx_stall = !cmd.rx_en;
  assign crc_base = (byte_count == '0) ? mrtu_pkg::CRC_INIT : rx_crc;

  // receive side
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (rx_data.frame_end) begin
        byte_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (store) begin
        byte_count <= byte_count + CW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx_data.frame_end) begin
      len    <= byte_count + CW'(store);
      len_ov <= overflow_seen || !store;
    end
    if (store) begin
      frame_mem[byte_count[AW-1:0]] <= rx_data.rx_byte;
      rx_crc <= mrtu_pkg::crc_byte(crc_base, rx_data.rx_byte);
      if (byte_count == CW'(mrtu_pkg::IDX_STATION)) station <= rx_data.rx_byte;
      if (byte_count == CW'(mrtu_pkg::IDX_FUNC))    func    <= rx_data.rx_byte;
      if (byte_count == CW'(mrtu_pkg::IDX_ADDR_HI)) addr_hi <= rx_data.rx_byte;
      if (byte_count == CW'(mrtu_pkg::IDX_ADDR_LO)) addr_lo <= rx_data.rx_byte;
      if (byte_count == CW'(mrtu_pkg::IDX_COUNT))   count   <= rx_data.rx_byte;
      if (byte_count == CW'(mrtu_pkg::IDX_BCOUNT))  bcount  <= rx_data.rx_byte;
    end
  end

  // frame memory read port
  assign wr_off = CW'(mrtu_pkg::IDX_WR_DATA) + {k[CW-2:0], 1'b0};

  always_comb begin
    case (cmd.rd_sel)
      mrtu_pkg::RD_WR_HI: rd_addr = wr_off[AW-1:0];
      mrtu_pkg::RD_WR_LO: rd_addr = wr_off[AW-1:0] + AW'(1);
      default:            rd_addr = k[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= frame_mem[rd_addr];
    if (cmd.hi_latch) hi_byte <= rd_data;
  end

  // request checks
  assign addr     = {addr_hi, addr_lo};
  assign addr_sum = {1'b0, addr} + 17'(count);
  assign base_ok  = !len_ov && (len >= CW'(mrtu_pkg::MIN_FRAME)) &&
                    (station == mrtu_pkg::BROADCAST || station == holding_regs[1][7:0]) &&
                    (rx_crc == 16'h0000);

  always_comb begin
    st.frame_done  = accept && rx_data.frame_end;
    st.ok_rd_regs  = base_ok && (func == mrtu_pkg::FN_READ_REGS) &&
                     (addr_sum <= 17'(mrtu_pkg::HOLDING_COUNT)) &&
                     (count <= 8'(mrtu_pkg::RD_MAX_COUNT));
    st.ok_wr_regs  = base_ok && (func == mrtu_pkg::FN_WRITE_REGS) &&
                     (addr_sum <= 17'(mrtu_pkg::WR_LIMIT)) &&
                     ({1'b0, bcount} == {count, 1'b0}) &&
                     (10'(len) >= 10'(mrtu_pkg::IDX_WR_DATA + 2) + {1'b0, count, 1'b0});
    st.ok_rd_coils = base_ok && (func == mrtu_pkg::FN_READ_COILS) &&
                     (addr >= 16'd1) && (addr <= 16'(mrtu_pkg::COIL_COUNT)) &&
                     (addr_sum <= 17'(mrtu_pkg::COIL_COUNT + 1));
    st.ok_wr_coil  = base_ok && (func == mrtu_pkg::FN_WRITE_COIL) &&
                     (addr >= 16'd1) && (addr <= 16'(mrtu_pkg::COIL_COUNT)) &&
                     (len <= CW'(mrtu_pkg::MAX_OUT));
    st.count_zero  = (count == 8'd0);
    st.wr_last     = (k + CW'(1) == CW'(count));
    st.tx_free     = !tx_valid || !tx_stall;
    st.resp_last   = (k + CW'(1) == resp_len);
  end

  always_comb begin
    case (func)
      mrtu_pkg::FN_READ_REGS:  resp_len_calc = CW'({count, 1'b0}) + CW'(mrtu_pkg::RESP_OVH);
      mrtu_pkg::FN_WRITE_REGS: resp_len_calc = CW'(mrtu_pkg::RESP_WR_LEN);
      mrtu_pkg::FN_READ_COILS: resp_len_calc = CW'(count) + CW'(mrtu_pkg::RESP_OVH);
      default:                 resp_len_calc = len;
    endcase
  end

  // register file
  assign coils       = holding_regs[0][mrtu_pkg::COIL_COUNT-1:0];
  assign coil_wr_idx = addr_lo[PW-1:0] - PW'(1);
  assign wr_idx      = addr_lo[HW-1:0] + k[HW-1:0];

  always_comb begin
    coils_next = coils;
    coils_next[coil_wr_idx] = (count == mrtu_pkg::COIL_ON);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mrtu_pkg::HOLDING_COUNT; r++) begin
        holding_regs[r] <= '0;
      end
      holding_regs[1] <= 16'd1;
    end else begin
      if (cmd.coil_wr) begin
        holding_regs[0] <= {holding_regs[0][15:mrtu_pkg::COIL_COUNT], coils_next};
      end
      if (cmd.reg_wr) begin
        for (int r = 0; r < mrtu_pkg::HOLDING_COUNT; r++) begin
          if (wr_idx == HW'(r)) holding_regs[r] <= {hi_byte, rd_data};
        end
      end
    end
  end

  // response bytes
  assign j           = k - CW'(mrtu_pkg::RESP_HDR);
  assign rd_idx      = CW'(addr_lo) + (j >> 1);
  assign coil_rd_idx = addr_lo[PW-1:0] - PW'(1) + j[PW-1:0];
  assign crc_lo      = (k + CW'(2) == resp_len);
  assign crc_hi      = (k + CW'(1) == resp_len);

  always_comb begin
    rd_word = '0;
    for (int r = 0; r < mrtu_pkg::HOLDING_COUNT; r++) begin
      if (rd_idx == CW'(r)) rd_word = holding_regs[r];
    end
  end

  always_comb begin
    resp_byte = rd_data;
    if (func != mrtu_pkg::FN_WRITE_COIL && crc_lo) begin
      resp_byte = tx_crc[7:0];
    end else if (func != mrtu_pkg::FN_WRITE_COIL && crc_hi) begin
      resp_byte = tx_crc[15:8];
    end else begin
      case (func)
        mrtu_pkg::FN_READ_REGS: begin
          if (k == CW'(mrtu_pkg::RESP_CNT_POS)) resp_byte = {count[6:0], 1'b0};
          else if (k > CW'(mrtu_pkg::RESP_CNT_POS)) resp_byte = j[0] ? rd_word[7:0] : rd_word[15:8];
        end
        mrtu_pkg::FN_READ_COILS: begin
          if (k == CW'(mrtu_pkg::RESP_CNT_POS)) resp_byte = count;
          else if (k > CW'(mrtu_pkg::RESP_CNT_POS)) resp_byte = {7'd0, coils[coil_rd_idx]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_start) begin
      k        <= '0;
      resp_len <= resp_len_calc;
      tx_crc   <= mrtu_pkg::CRC_INIT;
    end else if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.reg_wr || cmd.tx_load) begin
      k <= k + CW'(1);
    end
    if (cmd.tx_load) begin
      tx_data <= '{tx_byte: resp_byte, tx_last: st.resp_last};
      if (k + CW'(2) < resp_len) tx_crc <= mrtu_pkg::crc_byte(tx_crc, resp_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (cmd.tx_load) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/modbus_rtu_slave_frame_handler.sv
// Modbus RTU slave frame handler.
// rx channel: one frame byte per beat, frame_end set on the last byte. Bytes are
// taken one per cycle while a frame is being collected; rx_stall rises after
// the frame_end beat and stays high until the response has been handed off.
// tx channel: one response byte per beat, CRC low byte before high byte,
// tx_last on the final byte. Dropped frames give no tx beats.
// After the frame_end beat come a check state, then for a register write the
// states WR_HI, WR_MID and WR_LO per register (frame memory read twice per
// register) or a COIL state for a coil write, then for each response byte a
// frame memory read followed by a load of the output register. While tx_stall
// holds a beat in the output register, the load of the next byte waits.
// The output register holds one beat: a stalled beat stays put, the next byte
// waits, and the next frame can begin while the last beat still waits.
// Reset (rst, synchronous): holding register 1 becomes 1, all others 0, byte
// count and overflow flag clear, tx_valid drops. Frame memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_frame_handler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_stall,
  input  mrtu_pkg::rx_beat_t rx_data,
  output logic               tx_valid,
  input  wire logic          tx_stall,
  output mrtu_pkg::tx_beat_t tx_data
);

  mrtu_pkg::ctl_cmd_t   cmd;
  mrtu_pkg::dp_status_t st;

  mrtu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  mrtu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_data  (rx_data),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_data  (tx_data)
  );

endmodule

`default_nettype wire

>>> hdl/mrtu_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_slave_frame_handler_macros.svh"

module mrtu_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          rx_valid,
  input wire logic          rx_stall,
  input mrtu_pkg::rx_beat_t rx_data,
  input wire logic          tx_valid,
  input wire logic          tx_stall,
  input mrtu_pkg::tx_beat_t tx_data
);

  `MRTU_ASSERT(a_tx_hold, tx_valid && tx_stall |=> tx_valid && $stable(tx_data), "tx beat changed under stall")
  `MRTU_ASSERT(a_end_stalls, rx_valid && !rx_stall && rx_data.frame_end |=> rx_stall, "rx open after frame end")
  `MRTU_ASSERT(a_mid_open, rx_valid && !rx_stall && !rx_data.frame_end |=> !rx_stall, "rx stalled mid frame")
  `MRTU_ASSERT_ALWAYS(a_rst_idle, rst |=> !tx_valid, "tx valid after reset")

endmodule

bind modbus_rtu_slave_frame_handler mrtu_chk u_chk (.*);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mrtu_pkg::*;

  localparam int RAND_BEATS  = 380;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * MAX_OUT + 16;
  localparam logic [7:0] FN_UNUSED   = 8'h04;
  localparam logic [7:0] FN_ALL_ONES = 8'hFF;

  typedef enum {TW_NONE, TW_SHORT, TW_BADCRC, TW_OVER, TW_BCBAD, TW_DSHORT, TW_PAD, TW_JUNK}
    tweak_e;
  typedef enum {EXP_PRED, EXP_NONE, EXP_TYPED} exp_e;

  typedef struct {
    tweak_e      tw;
    logic [7:0]  sta;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [15:0] d0;
    exp_e        ex;
    int          tlen;
    logic [95:0] tbytes;
  } req_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     rx_valid = 1'b0;
  rx_beat_t rx_data = '0;
  logic     tx_stall = 1'b0;
  logic     rx_stall;
  logic     tx_valid;
  tx_beat_t tx_data;

  modbus_rtu_slave_frame_handler i_dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_data  (rx_data),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_data  (tx_data)
  );

  always #4 clk = ~clk;

  // shadow of the slave
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [15:0] hold_regs [HOLDING_COUNT];
  int unsigned frame_len;
  bit          frame_ovf;

  logic [7:0] frm[$];
  logic [7:0] rsp[$];
  tx_beat_t   resp_q[$];
  tx_beat_t   tx_want;

  int rx_idle_pct = 0;
  int tx_stall_pct = 0;
  bit hold_req = 1'b0;
  logic hold_on = 1'b0;

  int err_cnt = 0;
  int beats_sent = 0;
  int frames_sent = 0;
  int rsp_beats = 0;
  int rsp_frames = 0;
  int n_dir = 0;

  req_row_t dir_tab [26];
  req_row_t row;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic void append_rsp_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (rsp[i]) c = crc_step(c, rsp[i]);
    rsp.push_back(c[7:0]);
    rsp.push_back(c[15:8]);
  endfunction

  function automatic void shadow_reset();
    foreach (hold_regs[i]) hold_regs[i] = '0;
    hold_regs[1] = 16'd1;
    frame_len = 0;
    frame_ovf = 1'b0;
  endfunction

  // one accepted rx beat; leaves the response bytes in rsp
  function automatic void shadow_beat(rx_beat_t b);
    int unsigned len, a, n;
    bit ov;
    logic [15:0] c, bitm;
    rsp.delete();
    if (frame_len < FRAME_BYTES) begin
      frame_mem[frame_len] = b.rx_byte;
      frame_len++;
    end else begin
      frame_ovf = 1'b1;
    end
    if (!b.frame_end) return;
    len = frame_len;
    ov = frame_ovf;
    frame_len = 0;
    frame_ovf = 1'b0;
    if (ov || len < MIN_FRAME) return;
    if (frame_mem[0] != BROADCAST && frame_mem[0] != hold_regs[1][7:0]) return;
    c = CRC_INIT;
    for (int i = 0; i < len; i++) c = crc_step(c, frame_mem[i]);
    if (c != 16'h0000) return;
    a = {frame_mem[2], frame_mem[3]};
    n = frame_mem[5];
    case (frame_mem[1])
      FN_READ_REGS: begin
        if (a + n <= HOLDING_COUNT && 5 + 2 * n <= MAX_OUT) begin
          rsp = {frame_mem[0], frame_mem[1], 8'(2 * n)};
          for (int i = 0; i < n; i++) begin
            rsp.push_back(hold_regs[a + i][15:8]);
            rsp.push_back(hold_regs[a + i][7:0]);
          end
          append_rsp_crc();
        end
      end
      FN_WRITE_REGS: begin
        if (a + n <= WR_LIMIT && frame_mem[6] == 2 * n && len >= 9 + 2 * n) begin
          for (int i = 0; i < n; i++)
            hold_regs[a + i] = {frame_mem[7 + 2 * i], frame_mem[8 + 2 * i]};
          for (int i = 0; i < 6; i++) rsp.push_back(frame_mem[i]);
          append_rsp_crc();
        end
      end
      FN_READ_COILS: begin
        if (a >= 1 && a <= COIL_COUNT && n + a - 1 <= COIL_COUNT) begin
          rsp = {frame_mem[0], frame_mem[1], 8'(n)};
          for (int i = 0; i < n; i++)
            rsp.push_back({7'd0, hold_regs[0][(a - 1 + i) & 7]});
          append_rsp_crc();
        end
      end
      FN_WRITE_COIL: begin
        if (a >= 1 && a <= COIL_COUNT && len <= MAX_OUT) begin
          bitm = 16'd1 << (a - 1);
          if (frame_mem[5] == COIL_ON) hold_regs[0] = hold_regs[0] | bitm;
          else hold_regs[0] = hold_regs[0] & ~bitm;
          for (int i = 0; i < len; i++) rsp.push_back(frame_mem[i]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_rsp();
    foreach (rsp[i])
      resp_q.push_back(tx_beat_t'{tx_byte: rsp[i], tx_last: (i == rsp.size() - 1)});
  endfunction

  task automatic build_frame(input req_row_t r);
    int unsigned n, nd, tgt;
    logic [15:0] w, c;
    logic [7:0] flip;
    frm.delete();
    if (r.tw == TW_JUNK) begin
      repeat ($urandom_range(1, 12)) frm.push_back(8'($urandom));
      return;
    end
    frm = {r.sta, r.fn, r.addr[15:8], r.addr[7:0], r.cnt[15:8], r.cnt[7:0]};
    if (r.tw == TW_SHORT) begin
      void'(frm.pop_back());
    end else if (r.fn == FN_WRITE_REGS) begin
      n = r.cnt[7:0];
      frm.push_back((r.tw == TW_BCBAD) ? 8'(2 * n + 1) : 8'(2 * n));
      nd = (r.tw == TW_DSHORT && n > 0) ? n - 1 : n;
      for (int i = 0; i < nd; i++) begin
        w = i[0] ? ~r.d0 : r.d0;
        frm.push_back(w[15:8]);
        frm.push_back(w[7:0]);
      end
    end
    if (r.tw == TW_PAD) repeat ($urandom_range(1, 6)) frm.push_back(8'($urandom));
    if (r.tw == TW_OVER) begin
      tgt = FRAME_BYTES + $urandom_range(0, 6);
      while (frm.size() < tgt) frm.push_back(8'($urandom));
    end
    c = CRC_INIT;
    foreach (frm[i]) c = crc_step(c, frm[i]);
    flip = (r.tw == TW_BADCRC) ? (8'h01 << $urandom_range(0, 7)) : 8'h00;
    frm.push_back(c[7:0]);
    frm.push_back(c[15:8] ^ flip);
  endtask

  task automatic send_frame(input req_row_t r);
    int unsigned gap;
    rx_beat_t b;
    for (int i = 0; i < frm.size(); i++) begin
      gap = 0;
      while ($urandom_range(99) < rx_idle_pct) gap++;
      if (gap != 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      b.rx_byte = frm[i];
      b.frame_end = (i == frm.size() - 1);
      rx_valid <= 1'b1;
      rx_data <= b;
      @(posedge clk);
      while (rx_stall) @(posedge clk);
      beats_sent++;
      shadow_beat(b);
    end
    frames_sent++;
    case (r.ex)
      EXP_PRED: queue_rsp();
      EXP_TYPED: begin
        rsp.delete();
        for (int i = 0; i < r.tlen; i++) rsp.push_back(r.tbytes[8 * (r.tlen - 1 - i) +: 8]);
        append_rsp_crc();
        queue_rsp();
      end
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    rx_valid <= 1'b0;
    do @(posedge clk); while (resp_q.size() != 0);
  endtask

  task automatic pick_rand_row(output req_row_t r);
    int unsigned k;
    k = $urandom_range(99);
    r.tw = TW_NONE;
    r.ex = EXP_PRED;
    r.tlen = 0;
    r.tbytes = '0;
    r.d0 = 16'($urandom);
    case ($urandom_range(9))
      7, 8:    r.sta = BROADCAST;
      9:       r.sta = 8'($urandom);
      default: r.sta = hold_regs[1][7:0];
    endcase
    case ($urandom_range(3))
      0:       r.fn = FN_READ_REGS;
      1:       r.fn = FN_WRITE_REGS;
      2:       r.fn = FN_READ_COILS;
      default: r.fn = FN_WRITE_COIL;
    endcase
    r.addr = 16'($urandom_range(0, 10));
    if ($urandom_range(15) == 0) r.addr = 16'($urandom);
    r.cnt = {8'($urandom), 8'($urandom_range(0, 11))};
    if (k >= 90 && k <= 94) r.fn = FN_WRITE_REGS;
    if (r.fn == FN_WRITE_REGS) begin
      r.addr = 16'($urandom_range(0, 4));
      r.cnt[7:0] = 8'($urandom_range(0, 4 - (r.addr < 4 ? r.addr : 3) + 1));
    end
    if (r.fn == FN_WRITE_COIL && $urandom_range(1)) r.cnt[7:0] = COIL_ON;
    if (k < 80 && $urandom_range(5) == 0) r.tw = TW_PAD;
    else if (k >= 80 && k <= 83) r.tw = TW_SHORT;
    else if (k >= 84 && k <= 87) r.tw = TW_BADCRC;
    else if (k >= 88 && k <= 89) r.tw = TW_OVER;
    else if (k >= 90 && k <= 92) r.tw = TW_BCBAD;
    else if (k >= 93 && k <= 94) r.tw = TW_DSHORT;
    else if (k >= 95 && k <= 96) r.tw = TW_JUNK;
    else if (k >= 97) r.fn = 8'($urandom);
  endtask

  function automatic void note_mismatch(string what, tx_beat_t want, tx_beat_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.tx_byte, want.tx_last, got.tx_byte, got.tx_last);
  endfunction

  // response side: random stall plus one long hold
  always @(posedge clk) tx_stall <= hold_on || ($urandom_range(99) < tx_stall_pct);

  initial begin
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && tx_valid && !tx_stall) begin
      rsp_beats++;
      if (tx_data.tx_last) rsp_frames++;
      if (resp_q.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, tx_data);
      end else begin
        tx_want = resp_q.pop_front();
        if (tx_data.tx_byte !== tx_want.tx_byte || tx_data.tx_last !== tx_want.tx_last)
          note_mismatch("response beat", tx_want, tx_data);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("modbus_rtu_slave_frame_handler regression: fail");
    $finish;
  end

  initial begin
    dir_tab = '{
      '{TW_NONE,   8'h01, FN_READ_REGS,  16'h0001, 16'h0001, 16'h0000, EXP_TYPED, 5,
        96'h01_03_02_00_01},
      '{TW_NONE,   8'h01, FN_READ_COILS, 16'h0001, 16'h0008, 16'h0000, EXP_TYPED, 11,
        96'h01_01_08_00_00_00_00_00_00_00_00},
      '{TW_NONE,   BROADCAST, FN_READ_REGS, 16'h0000, 16'h000A, 16'h0000, EXP_PRED, 0, '0},
      '{TW_SHORT,  8'h01, FN_READ_REGS,  16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h02, FN_READ_REGS,  16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_BADCRC, 8'h01, FN_READ_REGS,  16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_UNUSED,     16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   BROADCAST, FN_ALL_ONES, 16'hFFFF, 16'hFFFF, 16'h0000, EXP_NONE, 0, '0},
      '{TW_OVER,   8'h01, FN_READ_REGS,  16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_REGS,  16'h0009, 16'h0002, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_REGS,  16'hFFFF, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_WRITE_REGS, 16'h0000, 16'h0004, 16'hFF00, EXP_PRED, 0, '0},
      '{TW_NONE,   8'hFF, FN_READ_REGS,  16'h0000, 16'hFF04, 16'h0000, EXP_PRED, 0, '0},
      '{TW_NONE,   8'hFF, FN_WRITE_REGS, 16'h0003, 16'h0002, 16'h1234, EXP_NONE, 0, '0},
      '{TW_BCBAD,  8'hFF, FN_WRITE_REGS, 16'h0000, 16'h0001, 16'h1234, EXP_NONE, 0, '0},
      '{TW_DSHORT, 8'hFF, FN_WRITE_REGS, 16'h0000, 16'h0002, 16'h1234, EXP_NONE, 0, '0},
      '{TW_NONE,   8'hFF, FN_WRITE_REGS, 16'h0000, 16'h0000, 16'h0000, EXP_PRED, 0, '0},
      '{TW_NONE,   8'hFF, FN_WRITE_REGS, 16'h0001, 16'h0001, 16'h0001, EXP_PRED, 0, '0},
      '{TW_NONE,   8'h01, FN_WRITE_COIL, 16'h0001, {8'h00, COIL_ON}, 16'h0000, EXP_PRED, 0, '0},
      '{TW_PAD,    8'h01, FN_WRITE_COIL, 16'h0008, 16'hFF00, 16'h0000, EXP_PRED, 0, '0},
      '{TW_NONE,   8'h01, FN_WRITE_COIL, 16'h0000, {8'h00, COIL_ON}, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_WRITE_COIL, 16'h0009, {8'h00, COIL_ON}, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_COILS, 16'h0008, 16'h0001, 16'h0000, EXP_PRED, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_COILS, 16'h0002, 16'h0008, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_COILS, 16'h0000, 16'h0001, 16'h0000, EXP_NONE, 0, '0},
      '{TW_NONE,   8'h01, FN_READ_COILS, 16'h0001, 16'h0000, 16'h0000, EXP_PRED, 0, '0}
    };
    shadow_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      build_frame(dir_tab[i]);
      send_frame(dir_tab[i]);
    end
    n_dir = frames_sent;
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin rx_idle_pct = 0;  tx_stall_pct = 0;  end
        1: begin rx_idle_pct = 56; tx_stall_pct = 0;  end
        2: begin rx_idle_pct = 0;  tx_stall_pct = 56; hold_req = 1'b1; end
        default: begin rx_idle_pct = 21; tx_stall_pct = 21; end
      endcase
      while (beats_sent - 0 < 0 || (beats_sent >= 0 &&
             (beats_sent - (ph == 0 ? beats_sent : 0)) < 0)) ;
      begin : ph_body
        int stop_at;
        stop_at = beats_sent + RAND_BEATS / 4;
        while (beats_sent < stop_at) begin
          pick_rand_row(row);
          build_frame(row);
          send_frame(row);
        end
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d directed and %0d random frames, %0d request beats",
             n_dir, frames_sent - n_dir, beats_sent);
    $display("checked %0d response beats in %0d responses, long output hold included, %0d bad",
             rsp_beats, rsp_frames, err_cnt);
    if (err_cnt == 0) begin
      $display("modbus_rtu_slave_frame_handler regression: pass");
    end else begin
      $display("modbus_rtu_slave_frame_handler regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/mrtu_pkg.sv
hdl/mrtu_ctrl.sv
hdl/mrtu_dp.sv
hdl/modbus_rtu_slave_frame_handler.sv
hdl/mrtu_chk.sv
dv/tb.sv
